// ===== design/twr_pkg.sv =====
// Shared types, constants and helpers for the time-window rule matcher.
package twr_pkg;

  // Table geometry
  localparam int NUM_RULES = 16;
  localparam int IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

  // Field widths fixed by the item format
  localparam int RIDX_W = 4;
  localparam int WORD_W = 32;
  localparam int TIME_W = 16;

  // Opcodes
  localparam logic [1:0] OP_EVAL  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Time limits and brightness levels
  localparam logic [7:0] HOURS_PER_DAY    = 8'd24;
  localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;
  localparam logic [2:0] BRIGHT_IN        = 3'd7;
  localparam logic [2:0] BRIGHT_OUT       = 3'd1;

  // Last scan counter value: data for entry NUM_RULES-2 is on the read port
  localparam logic [IDX_W-1:0] LAST_SCAN = IDX_W'(NUM_RULES - 1);

  typedef struct packed {
    logic [1:0]        opcode;
    logic [RIDX_W-1:0] rule_index;
    logic [WORD_W-1:0] rule_word;
    logic [4:0]        hour;
    logic [5:0]        minute;
  } twr_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              alarm_active;
    logic              brightness_update;
    logic [2:0]        brightness;
  } twr_out_t;

  // Request from the sequencer to the rule table
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
  } twr_mem_req_t;

  // Verdict of the window unit on one rule word
  typedef struct packed {
    logic valid;
    logic holds;
  } twr_chk_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } twr_state_t;

  // Map an item index onto a table address
  function automatic logic [IDX_W-1:0] to_addr(logic [RIDX_W-1:0] idx);
    return IDX_W'(idx);
  endfunction

  // True when an item index names an entry of the table
  function automatic logic idx_in_range(logic [RIDX_W-1:0] idx);
    return {3'b000, idx} < 7'(NUM_RULES);
  endfunction

endpackage

// ===== design/time_window_rule_matcher.sv =====
// Top level of the time-window rule matcher.
//
// Items arrive on the in_ channel (valid/ready, payload in_data) and each
// one gives exactly one result word on the out_ channel (payload out_data).
// A write stores rule_word at rule_index and returns an all-zero word. A read
// returns the stored word (zero for unwritten entries or out-of-range index).
// An evaluate scans entries 0 to NUM_RULES-2 through one shared compare
// unit, one entry per cycle from a registered table read port, and reports
// alarm_active plus the brightness decision from entry NUM_RULES-2.
// A write passes through ST_DONE, a read through ST_READ then ST_DONE, and an
// evaluate through the scan and then ST_DONE before its result is registered.
// One item is in flight at a time; in_ready is high only while idle. The output
// register holds a result until taken, so the next item may be accepted while
// out_valid waits on a stalled receiver; a finished result then waits inside
// until the output register frees up. Reset clears the sequencer, the output
// valid and all table entries (they read as zero until written), with no sweep.
module time_window_rule_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  twr_pkg::twr_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output twr_pkg::twr_out_t  out_data
);
  import twr_pkg::*;

  twr_mem_req_t      mem_req;
  logic [WORD_W-1:0] rd_data;
  logic [TIME_W-1:0] cur_time;
  twr_chk_t          chk;

  twr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .cur_time  (cur_time),
    .chk       (chk)
  );

  twr_rule_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  twr_window_unit u_win (
    .word     (rd_data),
    .cur_time (cur_time),
    .chk      (chk)
  );

endmodule

// ===== design/twr_rule_mem.sv =====
// Rule table: one write port, one registered read port, per-entry valid bits.
module twr_rule_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  twr_pkg::twr_mem_req_t        req,
  output logic [twr_pkg::WORD_W-1:0]   rd_data
);
  import twr_pkg::*;

  logic [WORD_W-1:0] mem [NUM_RULES];
  logic [NUM_RULES-1:0] vld_r;
  logic [WORD_W-1:0] q_r;
  logic              q_vld_r;

  // Store words
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    q_r <= mem[req.rd_addr];
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      q_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// ===== design/twr_window_unit.sv =====
// Shared compare unit: checks one rule word for validity and time containment.
module twr_window_unit (
  input  logic [twr_pkg::WORD_W-1:0] word,
  input  logic [twr_pkg::TIME_W-1:0] cur_time,
  output twr_pkg::twr_chk_t          chk
);
  import twr_pkg::*;

  logic [7:0]  on_m, on_h, off_m, off_h;
  logic [15:0] on_t, off_t;
  logic        fields_ok;

  assign on_m  = word[7:0];
  assign on_h  = word[15:8];
  assign off_m = word[23:16];
  assign off_h = word[31:24];
  assign on_t  = word[15:0];
  assign off_t = word[31:16];

  // Check field ranges
  assign fields_ok = (on_h < HOURS_PER_DAY) && (on_m < MINUTES_PER_HOUR) &&
                     (off_h < HOURS_PER_DAY) && (off_m < MINUTES_PER_HOUR);

  assign chk.valid = fields_ok && (on_t < off_t);
  assign chk.holds = (on_t <= cur_time) && (cur_time < off_t);

endmodule

// ===== design/twr_ctrl.sv =====
// Sequencer: decodes items, scans the table and holds the result word.
module twr_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  twr_pkg::twr_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output twr_pkg::twr_out_t          out_data,
  output twr_pkg::twr_mem_req_t      mem_req,
  input  logic [twr_pkg::WORD_W-1:0] rd_data,
  output logic [twr_pkg::TIME_W-1:0] cur_time,
  input  twr_pkg::twr_chk_t          chk
);
  import twr_pkg::*;

  twr_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic             hit_r, hit_nxt;
  logic             rng_r, rng_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  twr_out_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  twr_out_t         out_data_r, out_data_nxt;
  logic             hit_now;

  assign hit_now  = chk.valid && chk.holds;
  assign cur_time = time_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    hit_r      <= hit_nxt;
    rng_r      <= rng_nxt;
    time_r     <= time_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt       = state_r;
    scan_nxt        = scan_r;
    hit_nxt         = hit_r;
    rng_nxt         = rng_r;
    time_nxt        = time_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    in_ready        = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = to_addr(in_data.rule_index);
    mem_req.wr_data = in_data.rule_word;
    mem_req.rd_addr = scan_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt = '0;
          case (in_data.opcode)
            OP_EVAL: begin
              mem_req.rd_addr = '0;
              scan_nxt  = IDX_W'(1);
              hit_nxt   = 1'b0;
              time_nxt  = {3'b000, in_data.hour, 2'b00, in_data.minute};
              state_nxt = ST_SCAN;
            end
            OP_WRITE: begin
              mem_req.wr_en = idx_in_range(in_data.rule_index);
              state_nxt     = ST_DONE;
            end
            OP_READ: begin
              mem_req.rd_addr = to_addr(in_data.rule_index);
              rng_nxt         = idx_in_range(in_data.rule_index);
              state_nxt       = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Data on the read port belongs to entry scan_r-1
        if (hit_now) begin
          hit_nxt = 1'b1;
        end
        if (scan_r == LAST_SCAN) begin
          res_nxt.alarm_active = hit_r || hit_now;
          if (chk.valid) begin
            res_nxt.brightness_update = 1'b1;
            res_nxt.brightness        = chk.holds ? BRIGHT_IN : BRIGHT_OUT;
          end
          state_nxt = ST_DONE;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      ST_READ: begin
        res_nxt.read_word = rng_r ? rd_data : '0;
        state_nxt         = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Brightness is only nonzero with an update, and then is one of two levels
  a_bright_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.brightness_update && out_data.brightness == 3'd0) ||
                  (out_data.brightness_update &&
                   (out_data.brightness == BRIGHT_IN || out_data.brightness == BRIGHT_OUT)))
    else $error("twr_ctrl: bad brightness in result word");

  // A read result never carries evaluate flags
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.read_word != '0) |->
      (!out_data.alarm_active && !out_data.brightness_update))
    else $error("twr_ctrl: read word mixed with evaluate flags");

  // Scan counter never points back at entry zero during a scan
  a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r != '0))
    else $error("twr_ctrl: scan counter lost");

  // An accepted item always drops in_ready in the cycle after it is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("twr_ctrl: item overlap");

  // Scan advances by one each cycle until it finishes
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_r != LAST_SCAN) |=>
      (state_r == ST_SCAN && scan_r == $past(scan_r) + IDX_W'(1)))
    else $error("twr_ctrl: scan stalled or skipped");

endmodule

// ===== test/twr_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the time-window rule matcher: tracks the rule table and compares results.
module twr_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  twr_pkg::twr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  twr_pkg::twr_out_t out_data,
  output int                mismatch_count,
  output int                results_owed
);
  import twr_pkg::*;

  // Keep the log readable when something breaks badly
  localparam int MAX_REPORTS = 40;

  logic [WORD_W-1:0] rule_copy [NUM_RULES];
  twr_out_t          owed_q [$];
  twr_out_t          oldest;
  int                fails = 0;
  int                owed  = 0;

  assign mismatch_count = fails;
  assign results_owed   = owed;

  // Hours below a day, minutes below an hour, on strictly before off
  function automatic logic window_ok(logic [WORD_W-1:0] w);
    if (w[15:8] >= HOURS_PER_DAY || w[7:0] >= MINUTES_PER_HOUR) return 1'b0;
    if (w[31:24] >= HOURS_PER_DAY || w[23:16] >= MINUTES_PER_HOUR) return 1'b0;
    return w[15:0] < w[31:16];
  endfunction

  function automatic logic window_covers(logic [WORD_W-1:0] w, logic [TIME_W-1:0] now);
    return (w[15:0] <= now) && (now < w[31:16]);
  endfunction

  // Apply one input word to the table copy and return the result it should give
  function automatic twr_out_t apply_word(twr_in_t item);
    twr_out_t          res;
    logic [TIME_W-1:0] now;
    logic [WORD_W-1:0] w;
    res = '0;
    now = {3'b000, item.hour, 2'b00, item.minute};
    case (item.opcode)
      OP_WRITE: begin
        if (int'(item.rule_index) < NUM_RULES) rule_copy[item.rule_index] = item.rule_word;
      end
      OP_READ: begin
        if (int'(item.rule_index) < NUM_RULES) res.read_word = rule_copy[item.rule_index];
      end
      OP_EVAL: begin
        // Scan every entry but the last one
        for (int k = 0; k < NUM_RULES - 1; k++) begin
          if (window_ok(rule_copy[k]) && window_covers(rule_copy[k], now)) begin
            res.alarm_active = 1'b1;
          end
        end
        // The next-to-last entry also sets the brightness
        w = rule_copy[NUM_RULES - 2];
        if (window_ok(w)) begin
          res.brightness_update = 1'b1;
          res.brightness        = window_covers(w, now) ? BRIGHT_IN : BRIGHT_OUT;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (fails < MAX_REPORTS) begin
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (rule_copy[i]) rule_copy[i] = '0;
      owed_q.delete();
    end else begin
      // Retire the oldest expectation against each result word
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result with nothing owed", out_data.read_word, '0);
        end else begin
          oldest = owed_q.pop_front();
          if (out_data.read_word !== oldest.read_word)
            report_mismatch("read_word", out_data.read_word, oldest.read_word);
          if (out_data.alarm_active !== oldest.alarm_active)
            report_mismatch("alarm_active", out_data.alarm_active, oldest.alarm_active);
          if (out_data.brightness_update !== oldest.brightness_update)
            report_mismatch("brightness_update", out_data.brightness_update,
                            oldest.brightness_update);
          if (out_data.brightness !== oldest.brightness)
            report_mismatch("brightness", out_data.brightness, oldest.brightness);
        end
      end
      // Predict the result of each accepted input word
      if (in_valid && in_ready) owed_q.push_back(apply_word(in_data));
    end
    owed = owed_q.size();
  end

endmodule

// ===== test/time_window_rule_matcher_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the time-window rule matcher: clock, reset, stimulus and verdict.
module time_window_rule_matcher_tb;
  import twr_pkg::*;

  localparam logic [1:0] OP_NONE      = 2'd3;
  localparam int         BRIGHT_ENTRY = NUM_RULES - 2;
  localparam int         LAST_ENTRY   = NUM_RULES - 1;
  localparam int         RANDOM_WORDS = 1500;
  localparam int         QUIET_TAIL   = 200;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         DAY_MINUTES  = 1440;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  twr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  twr_out_t out_data;
  int       fail_total;
  int       owed_total;

  logic     quiet;
  logic     gap_phase;
  logic     stall_phase;
  // Words written so far, used to aim evaluate times at window edges
  logic [WORD_W-1:0] written [NUM_RULES];

  time_window_rule_matcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  twr_result_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (fail_total),
    .results_owed   (owed_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic twr_in_t make_word(logic [1:0] op, int idx, logic [WORD_W-1:0] rule,
                                        int hr, int mn);
    twr_in_t item;
    item.opcode     = op;
    item.rule_index = RIDX_W'(idx);
    item.rule_word  = rule;
    item.hour       = 5'(hr);
    item.minute     = 6'(mn);
    return item;
  endfunction

  // Pack on and off times (hour, minute) into a rule word
  function automatic logic [WORD_W-1:0] rule_of(int on_h, int on_m, int off_h, int off_m);
    return {8'(off_h), 8'(off_m), 8'(on_h), 8'(on_m)};
  endfunction

  // Window of up to four hours, well-formed unless it starts at the last minute of the day
  function automatic logic [WORD_W-1:0] make_window();
    int on_t;
    int off_t;
    on_t  = $urandom_range(0, DAY_MINUTES - 1);
    off_t = on_t + $urandom_range(1, 240);
    if (off_t > DAY_MINUTES - 1) off_t = DAY_MINUTES - 1;
    return rule_of(on_t / 60, on_t % 60, off_t / 60, off_t % 60);
  endfunction

  // Window broken in one way or another
  function automatic logic [WORD_W-1:0] spoil_window();
    logic [WORD_W-1:0] w;
    w = make_window();
    case ($urandom_range(0, 5))
      0: w = $urandom();
      1: w[15:8]  = 8'($urandom_range(24, 255));
      2: w[7:0]   = 8'($urandom_range(60, 255));
      3: w[31:24] = 8'($urandom_range(24, 255));
      4: w[23:16] = 8'($urandom_range(60, 255));
      default: w = {w[15:0], w[31:16]};
    endcase
    return w;
  endfunction

  // Evaluate word: plain times, times at or just before a stored window edge, or out-of-range times
  function automatic twr_in_t make_eval();
    twr_in_t           item;
    logic [WORD_W-1:0] w;
    int                pick;
    int                edge_t;
    item        = make_word(OP_EVAL, $urandom_range(0, 15), $urandom(), 0, 0);
    pick        = $urandom_range(0, 9);
    item.hour   = 5'($urandom_range(0, 23));
    item.minute = 6'($urandom_range(0, 59));
    if (pick >= 8) begin
      item.hour   = 5'($urandom());
      item.minute = 6'($urandom());
    end else if (pick >= 4) begin
      w = written[$urandom_range(0, NUM_RULES - 1)];
      if ($urandom_range(0, 1) == 1) edge_t = int'(w[31:24]) * 60 + int'(w[23:16]);
      else edge_t = int'(w[15:8]) * 60 + int'(w[7:0]);
      edge_t = edge_t - int'($urandom_range(0, 1));
      if (edge_t >= 0 && edge_t < DAY_MINUTES) begin
        item.hour   = 5'(edge_t / 60);
        item.minute = 6'(edge_t % 60);
      end
    end
    return item;
  endfunction

  // Present one word, with an optional gap first, and hold it until accepted
  task automatic send_word(input twr_in_t item);
    @(negedge clk);
    if (!quiet && gap_phase && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    if (item.opcode == OP_WRITE && int'(item.rule_index) < NUM_RULES)
      written[item.rule_index] = item.rule_word;
  endtask

  // Receiver: stall in bursts during stall phases
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) stall_phase = ~stall_phase;
      if (!quiet && stall_phase && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int r;
    int idx;
    logic [WORD_W-1:0] rule;
    twr_in_t item;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    gap_phase   = 1'b1;
    stall_phase = 1'b1;
    foreach (written[i]) written[i] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, brightness entry edges, unscanned last entry, broken rules
    send_word(make_word(OP_READ, 0, '1, 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 0, 0));
    send_word(make_word(OP_WRITE, BRIGHT_ENTRY, rule_of(8, 0, 17, 30), 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 7, 59));
    send_word(make_word(OP_EVAL, 0, '0, 8, 0));
    send_word(make_word(OP_EVAL, 0, '0, 17, 29));
    send_word(make_word(OP_EVAL, 0, '0, 17, 30));
    send_word(make_word(OP_EVAL, 15, '1, 31, 63));
    send_word(make_word(OP_READ, BRIGHT_ENTRY, '0, 0, 0));
    send_word(make_word(OP_WRITE, LAST_ENTRY, rule_of(0, 0, 23, 59), 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 3, 0));
    send_word(make_word(OP_READ, LAST_ENTRY, '0, 0, 0));
    send_word(make_word(OP_WRITE, 0, '1, 31, 63));
    send_word(make_word(OP_READ, 0, '0, 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 12, 0));
    send_word(make_word(OP_WRITE, BRIGHT_ENTRY, rule_of(10, 0, 10, 0), 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 10, 0));
    send_word(make_word(OP_WRITE, BRIGHT_ENTRY, rule_of(23, 0, 24, 0), 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 23, 30));
    send_word(make_word(OP_WRITE, 1, rule_of(5, 60, 6, 0), 0, 0));
    send_word(make_word(OP_WRITE, 2, rule_of(0, 0, 0, 1), 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 0, 0));
    send_word(make_word(OP_NONE, 15, '1, 31, 63));
    send_word(make_word(OP_WRITE, BRIGHT_ENTRY, '0, 0, 0));
    send_word(make_word(OP_EVAL, 0, '0, 5, 30));

    // Random: mostly valid windows and evaluates, some broken rules and noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) gap_phase = 1'($urandom_range(0, 1));
      quiet = (n >= RANDOM_WORDS - QUIET_TAIL);
      r     = $urandom_range(0, 99);
      if (r < 35) begin
        idx = $urandom_range(0, 15);
        if ($urandom_range(0, 9) < 3) idx = BRIGHT_ENTRY;
        else if ($urandom_range(0, 9) == 0) idx = LAST_ENTRY;
        r = $urandom_range(0, 99);
        if (r < 65) rule = make_window();
        else if (r < 80) rule = '0;
        else rule = spoil_window();
        item = make_word(OP_WRITE, idx, rule, $urandom(), $urandom());
      end else if (r < 55) begin
        item = make_word(OP_READ, $urandom_range(0, 15), $urandom(), $urandom(), $urandom());
      end else if (r < 96) begin
        item = make_eval();
      end else begin
        item = make_word(OP_NONE, $urandom_range(0, 15), $urandom(), $urandom(), $urandom());
      end
      send_word(item);
    end

    // Drain the remaining results
    @(negedge clk);
    in_valid = 1'b0;
    while (owed_total != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
